// ===== hdl/first_fit_block_allocator_unit_macros.svh =====
// assertion helpers shared by the allocator rtl
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk and held off during reset
`define FFBA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ffba_pkg.sv =====
package ffba_pkg;

    localparam int DATA_W     = 32;
    localparam int CFG_INDEX_W = 1;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_HEAP_BASE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEAP_LIMIT = 1'b1;

    localparam logic [DATA_W-1:0] HEAP_BASE_RESET  = 32'd4096;
    localparam logic [DATA_W-1:0] HEAP_LIMIT_RESET = 32'd65536;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_ZERO    = 3'd1,
        ST_OOM     = 3'd2,
        ST_NULL    = 3'd3,
        ST_UNKNOWN = 3'd4,
        ST_DOUBLE  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_APPEND
    } state_t;

    typedef enum logic [1:0] {
        ASEL_NONE,
        ASEL_HIT,
        ASEL_APPEND
    } addr_sel_t;

    typedef struct packed {
        logic              kind;
        logic [DATA_W-1:0] request_size;
        logic [DATA_W-1:0] block_address;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] payload_address;
        logic [2:0]        status;
    } result_t;

    typedef struct packed {
        logic              free;
        logic [DATA_W-1:0] size;
        logic [DATA_W-1:0] start;
    } entry_t;

    typedef struct packed {
        logic      latch;
        logic      scan_start;
        logic      scan;
        logic      wr_hit;
        logic      wr_append;
        logic      emit;
        status_t   code;
        addr_sel_t asel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_free;
        logic zero_req;
        logic null_addr;
        logic count_zero;
        logic check_valid;
        logic check_last;
        logic hit;
        logic hit_free;
        logic oom;
    } dp_status_t;

endpackage

// ===== hdl/ffba_ctrl.sv =====
module ffba_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  ffba_pkg::dp_status_t  dp_st,
    output ffba_pkg::ctrl_cmd_t   cmd
);
    import ffba_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.code       = ST_OK;
        cmd.asel       = ASEL_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.scan_start = 1'b1;
                if (dp_st.is_free)
                begin
                    if (dp_st.null_addr)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.code   = ST_NULL;
                        state_next = S_IDLE;
                    end
                    else if (dp_st.count_zero)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.code   = ST_UNKNOWN;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    if (dp_st.zero_req)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.code   = ST_ZERO;
                        state_next = S_IDLE;
                    end
                    else if (dp_st.count_zero)
                    begin
                        state_next = S_APPEND;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (dp_st.hit)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                    if (!dp_st.is_free)
                    begin
                        cmd.wr_hit = 1'b1;
                        cmd.code   = ST_OK;
                        cmd.asel   = ASEL_HIT;
                    end
                    else if (dp_st.hit_free)
                    begin
                        cmd.code = ST_DOUBLE;
                    end
                    else
                    begin
                        cmd.wr_hit = 1'b1;
                        cmd.code   = ST_OK;
                    end
                end
                else if (dp_st.check_valid && dp_st.check_last)
                begin
                    if (dp_st.is_free)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.code   = ST_UNKNOWN;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_APPEND;
                    end
                end
            end
            S_APPEND:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
                if (dp_st.oom)
                begin
                    cmd.code = ST_OOM;
                end
                else
                begin
                    cmd.wr_append = 1'b1;
                    cmd.code      = ST_OK;
                    cmd.asel      = ASEL_APPEND;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/ffba_datapath.sv =====
module ffba_datapath #(
    parameter int MAX_BLOCKS   = 16,
    parameter int HEADER_BYTES = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ffba_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [ffba_pkg::DATA_W-1:0]           cfg_data,
    input  ffba_pkg::item_t                       item,
    input  ffba_pkg::ctrl_cmd_t                   cmd,
    output ffba_pkg::dp_status_t                  dp_st,
    output logic                                  done,
    output ffba_pkg::result_t                     result
);
    import ffba_pkg::*;

    localparam int IDXW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNTW = $clog2(MAX_BLOCKS + 1);

    entry_t mem [MAX_BLOCKS];

    logic [DATA_W-1:0] heap_base_reg;
    logic [DATA_W-1:0] heap_limit_reg;
    logic [CNTW-1:0]   count_reg;
    logic [DATA_W-1:0] bytes_used_reg;
    logic [IDXW-1:0]   scan_idx_reg;
    logic [IDXW-1:0]   scan_idx_next;
    logic [IDXW-1:0]   check_idx_reg;
    logic              check_valid_reg;
    logic              done_reg;
    item_t             item_reg;
    entry_t            rd_data_reg;
    result_t           result_reg;
    result_t           result_next;

    logic [CNTW-1:0]   count_m1;
    logic [IDXW-1:0]   last_idx;
    logic [DATA_W-1:0] hit_addr;
    logic [DATA_W-1:0] append_start;
    logic [DATA_W-1:0] append_addr;
    logic [DATA_W+1:0] need;
    logic              alloc_match;
    logic              free_match;
    logic              wr_en;
    logic [IDXW-1:0]   wr_addr;
    entry_t            wr_data;

    assign count_m1     = count_reg - CNTW'(1);
    assign last_idx     = count_m1[IDXW-1:0];
    assign hit_addr     = rd_data_reg.start + DATA_W'(HEADER_BYTES);
    assign append_start = heap_base_reg + bytes_used_reg;
    assign append_addr  = append_start + DATA_W'(HEADER_BYTES);
    // exact sum, two spare bits so it cannot wrap
    assign need = {2'b00, bytes_used_reg} + (DATA_W + 2)'(HEADER_BYTES)
                + {2'b00, item_reg.request_size};

    assign alloc_match = rd_data_reg.free && (rd_data_reg.size >= item_reg.request_size);
    assign free_match  = (hit_addr == item_reg.block_address);

    always_comb
    begin
        dp_st             = '0;
        dp_st.is_free     = (item_reg.kind == KIND_FREE);
        dp_st.zero_req    = (item_reg.request_size == '0);
        dp_st.null_addr   = (item_reg.block_address == '0);
        dp_st.count_zero  = (count_reg == '0);
        dp_st.check_valid = check_valid_reg;
        dp_st.check_last  = (check_idx_reg == last_idx);
        dp_st.hit         = check_valid_reg && (dp_st.is_free ? free_match : alloc_match);
        dp_st.hit_free    = rd_data_reg.free;
        dp_st.oom         = (count_reg == CNTW'(MAX_BLOCKS))
                          || (need > {2'b00, heap_limit_reg});
    end

    // issue pointer stops on the last live entry
    always_comb
    begin
        scan_idx_next = scan_idx_reg;
        if (cmd.scan_start)
        begin
            scan_idx_next = '0;
        end
        else if (cmd.scan && (scan_idx_reg != last_idx))
        begin
            scan_idx_next = scan_idx_reg + IDXW'(1);
        end
    end

    assign wr_en   = cmd.wr_hit || cmd.wr_append;
    assign wr_addr = cmd.wr_append ? count_reg[IDXW-1:0] : check_idx_reg;

    always_comb
    begin
        if (cmd.wr_append)
        begin
            wr_data.free  = 1'b0;
            wr_data.size  = item_reg.request_size;
            wr_data.start = append_start;
        end
        else
        begin
            // reuse clears the mark, release sets it
            wr_data.free  = (item_reg.kind == KIND_FREE);
            wr_data.size  = rd_data_reg.size;
            wr_data.start = rd_data_reg.start;
        end
    end

    always_comb
    begin
        result_next.status = cmd.code;
        case (cmd.asel)
            ASEL_HIT:    result_next.payload_address = hit_addr;
            ASEL_APPEND: result_next.payload_address = append_addr;
            default:     result_next.payload_address = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.scan)
        begin
            rd_data_reg   <= mem[scan_idx_reg];
            check_idx_reg <= scan_idx_reg;
        end
        if (cmd.latch)
        begin
            item_reg <= item;
        end
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg   <= HEAP_BASE_RESET;
            heap_limit_reg  <= HEAP_LIMIT_RESET;
            count_reg       <= '0;
            bytes_used_reg  <= '0;
            scan_idx_reg    <= '0;
            check_valid_reg <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HEAP_BASE:  heap_base_reg  <= cfg_data;
                    REG_HEAP_LIMIT: heap_limit_reg <= cfg_data;
                    default:        heap_base_reg  <= heap_base_reg;
                endcase
            end
            if (cmd.wr_append)
            begin
                count_reg      <= count_reg + CNTW'(1);
                bytes_used_reg <= need[DATA_W-1:0];
            end
            scan_idx_reg    <= scan_idx_next;
            check_valid_reg <= cmd.scan;
            done_reg        <= cmd.emit;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== hdl/first_fit_block_allocator_unit.sv =====
// first-fit block allocator
// command channel: item (kind, request_size, block_address) is taken on a clock
// edge with start high and busy low; busy stays high until the result is issued
// result channel: done pulses for one cycle with result (payload_address, status);
// the receiver has no back-pressure, so each transfer is taken as it appears
// config port: cfg_we with cfg_index 0 writes heap_base, 1 writes heap_limit;
// writes land at once; the user must make them only while busy is low (not enforced)
// zero-size requests and null or empty-table frees end in the evaluate state; others
// scan the live entries for the first hit, then append or report a miss;
// the scan reads one table entry per cycle; the table has one read and one write port
// busy falls in the cycle done rises, so a new item may be started then
// items are handled one at a time; throughput is set by the table scan length
// reset clears the block count, used byte count and done flag, and loads
// the heap_base and heap_limit defaults; table contents need no clearing as
// entries past the block count are never read
module first_fit_block_allocator_unit #(
    parameter int MAX_BLOCKS   = 16,
    parameter int HEADER_BYTES = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  ffba_pkg::item_t                    item,
    output logic                               done,
    output ffba_pkg::result_t                  result,
    input  logic                               cfg_we,
    input  logic [ffba_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ffba_pkg::DATA_W-1:0]        cfg_data
);
    import ffba_pkg::*;

    `include "first_fit_block_allocator_unit_macros.svh"

    ctrl_cmd_t  cmd;
    dp_status_t dp_st;

    ffba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .dp_st (dp_st),
        .cmd   (cmd)
    );

    ffba_datapath #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (cmd),
        .dp_st     (dp_st),
        .done      (done),
        .result    (result)
    );

    `FFBA_ASSERT_SAME(a_done_after_busy, done, $past(busy), "result without a command in flight")
    `FFBA_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy, "accepted command did not raise busy")
    `FFBA_ASSERT_NEXT(a_single_result, done, !done, "more than one result for one command")
    `FFBA_ASSERT_SAME(a_fail_null_addr, done && (result.status != ST_OK), result.payload_address == '0, "failed request returned an address")
    `FFBA_ASSERT_SAME(a_write_one_kind, cmd.wr_hit, !cmd.wr_append, "table write from both reuse and append")

endmodule
